[design/eepq_pkg.sv]
// package for the eeprom page write queue
// holds result status codes, sequencer states and parameter defaults; no dependencies
package eepq_pkg;

  localparam int unsigned QueueDepthDef   = 16;
  localparam int unsigned PageBytesDef    = 8;
  localparam int unsigned MaxTaskBytesDef = 64;

  typedef enum logic [2:0] {
    ST_WRITE    = 3'd0,
    ST_QUEUED   = 3'd1,
    ST_FULL     = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_TOO_LONG = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_STREAM
  } seq_state_e;

endpackage

[design/eepq_if.sv]
// valid/ready channel interfaces for the eeprom page write queue
// request and result channels; no dependencies
interface eepq_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] data_byte;
  logic       last_byte;
  logic [7:0] start_page;
  logic [2:0] start_offset;

  modport source (output valid, operation, data_byte, last_byte, start_page, start_offset,
                  input ready);
  modport sink (input valid, operation, data_byte, last_byte, start_page, start_offset,
                output ready);
endinterface

interface eepq_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] page_number;
  logic [2:0] page_offset;
  logic [7:0] write_byte;
  logic       chunk_last;
  logic       task_finished;

  modport source (output valid, status, page_number, page_offset, write_byte, chunk_last,
                  task_finished, input ready);
  modport sink (input valid, status, page_number, page_offset, write_byte, chunk_last,
                task_finished, output ready);
endinterface

[design/eeprom_page_write_queue.sv]
// eeprom page write queue: task data bytes come in one transfer per byte and are held in a
// circular queue of write tasks; a service request streams the head task's next page chunk
// out one byte per transfer. enqueue bytes produce a result only on the last byte of a task
// or on a reject. a service request on an empty queue answers with an empty status; otherwise
// (chunk at most PAGE_BYTES) the task descriptor memory is read first, then one byte per cycle
// comes from the byte memory read port while the result side keeps taking transfers. no
// clearing pass after reset: only committed tasks are ever read. depends on eepq_pkg, eepq_if
// and eepq_ram.
module eeprom_page_write_queue import eepq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH    = QueueDepthDef,
  parameter int unsigned PAGE_BYTES     = PageBytesDef,
  parameter int unsigned MAX_TASK_BYTES = MaxTaskBytesDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  eepq_in_if.sink    req_i,
  eepq_out_if.source rsp_o
);

  // widths
  localparam int unsigned QW   = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNTW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned LW   = $clog2(MAX_TASK_BYTES + 1);
  localparam int unsigned BAW  = (MAX_TASK_BYTES > 1) ? $clog2(MAX_TASK_BYTES) : 1;
  localparam int unsigned PW   = $clog2(PAGE_BYTES);
  localparam int unsigned RW   = $clog2(PAGE_BYTES + 1);
  localparam int unsigned CW   = (LW > RW) ? LW : RW;
  localparam int unsigned DW   = LW + LW + 8 + PW;
  localparam int unsigned BDEPTH = QUEUE_DEPTH * (1 << BAW);

  // start offset wraps into the page, value is narrow so a few subtract steps do it
  function automatic logic [PW-1:0] wrap_offset(logic [2:0] v);
    logic [3:0] r;
    r = {1'b0, v};
    for (int i = 0; i < 8; i++) begin
      if (r >= 4'(PAGE_BYTES) && PAGE_BYTES < 8) begin
        r = r - 4'(PAGE_BYTES);
      end
    end
    return PW'(r);
  endfunction

  // control state
  seq_state_e       state_q, state_d;
  logic [QW-1:0]    head_q, head_d, tail_q, tail_d;
  logic [CNTW-1:0]  count_q, count_d;
  logic [LW-1:0]    fill_q, fill_d;
  logic             drop_q, drop_d;
  logic             out_valid_q, out_valid_d;

  // task being filled and chunk being streamed
  logic [7:0]       fpage_q, fpage_d;
  logic [PW-1:0]    foff_q, foff_d;
  logic [LW-1:0]    pos_q, pos_d;
  logic [RW-1:0]    left_q, left_d;
  logic [7:0]       spage_q, spage_d;
  logic [PW-1:0]    soff_q, soff_d;
  logic             fin_q, fin_d;
  logic [QW-1:0]    sh_q, sh_d;

  // result register
  status_e          o_status_q, o_status_d;
  logic [7:0]       o_page_q, o_page_d;
  logic [2:0]       o_off_q, o_off_d;
  logic [7:0]       o_byte_q, o_byte_d;
  logic             o_clast_q, o_clast_d;
  logic             o_fin_q, o_fin_d;
  logic             out_load;

  // memory ports
  logic                b_we, b_re;
  logic [QW+BAW-1:0]   b_waddr, b_raddr;
  logic [7:0]          b_wdata, b_rdata;
  logic                d_we, d_re;
  logic [QW-1:0]       d_waddr, d_raddr;
  logic [DW-1:0]       d_wdata, d_rdata;

  // descriptor fields as read
  logic [LW-1:0]  d_len, d_prog;
  logic [7:0]     d_page;
  logic [PW-1:0]  d_off;

  // chunk arithmetic
  logic [LW-1:0]  rem;
  logic [RW-1:0]  room, off_sum;
  logic [CW-1:0]  chunk;
  logic           finishes;

  logic out_free, accept;

  assign out_free = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE) && out_free;
  assign accept = req_i.valid && req_i.ready;

  assign {d_len, d_prog, d_page, d_off} = d_rdata;

  assign rem      = d_len - d_prog;
  assign room     = RW'(PAGE_BYTES) - RW'(d_off);
  assign chunk    = (CW'(rem) < CW'(room)) ? CW'(rem) : CW'(room);
  assign finishes = CW'(rem) <= CW'(room);
  assign off_sum  = RW'(d_off) + RW'(chunk);

  eepq_ram #(
    .Width (8),
    .Depth (BDEPTH),
    .AddrW (QW + BAW)
  ) u_bytes (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (b_wdata),
    .re_i    (b_re),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  eepq_ram #(
    .Width (DW),
    .Depth (QUEUE_DEPTH),
    .AddrW (QW)
  ) u_desc (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (d_waddr),
    .wdata_i (d_wdata),
    .re_i    (d_re),
    .raddr_i (d_raddr),
    .rdata_o (d_rdata)
  );

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    fill_d   = fill_q;
    drop_d   = drop_q;
    fpage_d  = fpage_q;
    foff_d   = foff_q;
    pos_d    = pos_q;
    left_d   = left_q;
    spage_d  = spage_q;
    soff_d   = soff_q;
    fin_d    = fin_q;
    sh_d     = sh_q;

    out_load   = 1'b0;
    o_status_d = ST_WRITE;
    o_page_d   = '0;
    o_off_d    = '0;
    o_byte_d   = '0;
    o_clast_d  = 1'b0;
    o_fin_d    = 1'b0;

    b_we    = 1'b0;
    b_waddr = {tail_q, fill_q[BAW-1:0]};
    b_wdata = req_i.data_byte;
    b_re    = 1'b0;
    b_raddr = {head_q, d_prog[BAW-1:0]};
    d_we    = 1'b0;
    d_waddr = tail_q;
    d_wdata = '0;
    d_re    = 1'b0;
    d_raddr = head_q;

    case (state_q)
      S_IDLE: begin
        if (accept && !req_i.operation) begin
          if (drop_q) begin
            // silently swallow the rest of a rejected task
            if (req_i.last_byte) begin
              drop_d = 1'b0;
            end
          end else if (fill_q == '0 && count_q == CNTW'(QUEUE_DEPTH)) begin
            drop_d     = !req_i.last_byte;
            out_load   = 1'b1;
            o_status_d = ST_FULL;
          end else if (fill_q >= LW'(MAX_TASK_BYTES)) begin
            fill_d     = '0;
            drop_d     = !req_i.last_byte;
            out_load   = 1'b1;
            o_status_d = ST_TOO_LONG;
          end else begin
            // first byte of a task latches its start position
            if (fill_q == '0) begin
              fpage_d = req_i.start_page;
              foff_d  = wrap_offset(req_i.start_offset);
            end
            b_we   = 1'b1;
            fill_d = fill_q + 1'b1;
            if (req_i.last_byte) begin
              // commit: tail slot is free since the queue was not full at the first byte
              d_we    = 1'b1;
              d_wdata = {LW'(fill_q + 1'b1), LW'(0), fpage_d, foff_d};
              fill_d  = '0;
              tail_d  = (tail_q == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
              count_d = count_q + 1'b1;
              out_load   = 1'b1;
              o_status_d = ST_QUEUED;
            end
          end
        end else if (accept) begin
          if (count_q == '0) begin
            out_load   = 1'b1;
            o_status_d = ST_EMPTY;
          end else begin
            d_re    = 1'b1;
            state_d = S_FETCH;
          end
        end
      end

      S_FETCH: begin
        // descriptor is out: set up the chunk, write back the advanced descriptor
        pos_d   = d_prog;
        left_d  = RW'(chunk);
        spage_d = d_page;
        soff_d  = d_off;
        fin_d   = finishes;
        sh_d    = head_q;
        b_re    = 1'b1;
        d_we    = 1'b1;
        d_waddr = head_q;
        if (off_sum >= RW'(PAGE_BYTES)) begin
          d_wdata = {d_len, d_prog + LW'(chunk), d_page + 8'd1, PW'(0)};
        end else begin
          d_wdata = {d_len, d_prog + LW'(chunk), d_page, PW'(off_sum)};
        end
        if (finishes) begin
          head_d  = (head_q == QW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
          count_d = count_q - 1'b1;
        end
        state_d = S_STREAM;
      end

      S_STREAM: begin
        // byte memory output stays put while the result side stalls
        if (out_free) begin
          out_load   = 1'b1;
          o_status_d = ST_WRITE;
          o_page_d   = spage_q;
          o_off_d    = 3'(soff_q);
          o_byte_d   = b_rdata;
          o_clast_d  = (left_q == RW'(1));
          o_fin_d    = fin_q;
          pos_d      = pos_q + 1'b1;
          left_d     = left_q - 1'b1;
          soff_d     = soff_q + 1'b1;
          if (left_q == RW'(1)) begin
            state_d = S_IDLE;
          end else begin
            b_re    = 1'b1;
            b_raddr = {sh_q, pos_d[BAW-1:0]};
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && !rsp_o.ready;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      fill_q      <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      fill_q      <= fill_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    fpage_q <= fpage_d;
    foff_q  <= foff_d;
    pos_q   <= pos_d;
    left_q  <= left_d;
    spage_q <= spage_d;
    soff_q  <= soff_d;
    fin_q   <= fin_d;
    sh_q    <= sh_d;
    if (out_load) begin
      o_status_q <= o_status_d;
      o_page_q   <= o_page_d;
      o_off_q    <= o_off_d;
      o_byte_q   <= o_byte_d;
      o_clast_q  <= o_clast_d;
      o_fin_q    <= o_fin_d;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = o_status_q;
  assign rsp_o.page_number   = o_page_q;
  assign rsp_o.page_offset   = o_off_q;
  assign rsp_o.write_byte    = o_byte_q;
  assign rsp_o.chunk_last    = o_clast_q;
  assign rsp_o.task_finished = o_fin_q;

  // queue occupancy never runs past the depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNTW'(QUEUE_DEPTH))
    else $error("task count above queue depth");

  // a task being dropped holds no partially filled bytes
  a_drop_no_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drop_q |-> (fill_q == '0))
    else $error("dropping while a task is filling");

  // the streaming counter never runs dry inside a chunk
  a_stream_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STREAM) |-> (left_q != '0))
    else $error("stream with no bytes left");

  // service on an empty queue answers with an empty status right away
  a_empty_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.operation && count_q == '0) |=>
      (out_valid_q && o_status_q == ST_EMPTY && state_q == S_IDLE))
    else $error("empty queue service not answered");

  // a fetch always moves on to streaming the chunk
  a_fetch_to_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FETCH) |=> (state_q == S_STREAM))
    else $error("fetch did not lead to stream");

endmodule

[design/eepq_ram.sv]
// simple dual port ram, one write port and one registered read port
// depends on nothing
module eepq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// testbench for eeprom_page_write_queue: directed and random request streams, with a mirror
// of the task queue predicting every result; needs eepq_pkg, eepq_if and the queue module
module tb_top;
  import eepq_pkg::*;

  localparam int unsigned QDEPTH = QueueDepthDef;
  localparam int unsigned PAGE   = PageBytesDef;
  localparam int unsigned MAXB   = MaxTaskBytesDef;

  // request operations
  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_SERVICE = 1'b1;

  localparam int unsigned HOLD_CYCLES    = 200;   // long receiver hold-off
  localparam int unsigned WATCHDOG_LIMIT = 1000;  // cycles without any transfer
  localparam int unsigned TAIL_CYCLES    = 20;    // extra wait before the final owed-results check

  typedef struct packed {
    status_e    status;
    logic [7:0] page;
    logic [2:0] offset;
    logic [7:0] data;
    logic       clast;
    logic       fin;
  } rsp_item_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  eepq_in_if  req_if ();
  eepq_out_if rsp_if ();

  eeprom_page_write_queue dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------------------
  // mirror of the task queue, updated at each accepted request transfer
  // ---------------------------------------------------------------------------------------
  logic [7:0] task_data_m [QDEPTH*MAXB];
  logic [6:0] task_len_m  [QDEPTH];
  logic [6:0] task_prog_m [QDEPTH];
  logic [7:0] task_page_m [QDEPTH];
  logic [2:0] task_off_m  [QDEPTH];
  logic [3:0] head_q  = '0;
  logic [3:0] tail_q  = '0;
  logic [4:0] count_q = '0;
  logic [6:0] fill_q  = '0;
  logic       drop_q  = 1'b0;

  rsp_item_t awaited_rsps [$];   // results still owed by the block, oldest first

  function automatic void push_status(input status_e st);
    rsp_item_t r;
    r = '0;
    r.status = st;
    awaited_rsps.push_back(r);
  endfunction

  function automatic void step_task_queue(input logic op, input logic [7:0] data,
                                          input logic last, input logic [7:0] page,
                                          input logic [2:0] off);
    int unsigned slot, remaining, room, chunk, next_off;
    bit          finishes;
    rsp_item_t   r;
    if (op == OP_ENQUEUE) begin
      slot = tail_q;
      // rest of a rejected task is swallowed up to its last-byte mark
      if (drop_q) begin
        if (last) drop_q = 1'b0;
        return;
      end
      if (fill_q == 0) begin
        if (count_q >= QDEPTH) begin
          drop_q = !last;
          push_status(ST_FULL);
          return;
        end
        task_page_m[slot] = page;
        task_off_m[slot]  = 3'(off % PAGE);
      end
      if (fill_q >= MAXB) begin
        fill_q = '0;
        drop_q = !last;
        push_status(ST_TOO_LONG);
        return;
      end
      task_data_m[slot*MAXB + fill_q] = data;
      fill_q++;
      if (!last) return;
      task_len_m[slot]  = fill_q;
      task_prog_m[slot] = '0;
      fill_q  = '0;
      tail_q  = 4'((slot + 1) % QDEPTH);
      count_q++;
      push_status(ST_QUEUED);
    end else begin
      // a task still being filled does not count as queued
      if (count_q == 0) begin
        push_status(ST_EMPTY);
        return;
      end
      slot      = head_q;
      remaining = (task_len_m[slot] > task_prog_m[slot]) ?
                  task_len_m[slot] - task_prog_m[slot] : 0;
      room      = PAGE - task_off_m[slot];
      chunk     = (remaining < room) ? remaining : room;
      finishes  = (task_prog_m[slot] + chunk) >= task_len_m[slot];
      for (int unsigned i = 0; i < chunk; i++) begin
        r.status = ST_WRITE;
        r.page   = task_page_m[slot];
        r.offset = 3'(task_off_m[slot] + i);
        r.data   = task_data_m[slot*MAXB + task_prog_m[slot] + i];
        r.clast  = (i + 1 == chunk);
        r.fin    = finishes;
        awaited_rsps.push_back(r);
      end
      task_prog_m[slot] = 7'(task_prog_m[slot] + chunk);
      next_off = task_off_m[slot] + chunk;
      // chunk reached the page end: move on to the next page, wrapping after 255
      if (next_off >= PAGE) begin
        task_page_m[slot] = task_page_m[slot] + 8'd1;
        task_off_m[slot]  = '0;
      end else begin
        task_off_m[slot] = 3'(next_off);
      end
      if (finishes) begin
        head_q = 4'((slot + 1) % QDEPTH);
        count_q--;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------------------
  int unsigned mismatch_count = 0;
  int unsigned items_sent     = 0;
  int unsigned results_seen   = 0;
  int unsigned status_seen [5];

  task automatic report_mismatch(input string msg);
    $display("mismatch at result %0d: %s", results_seen, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  always @(posedge clk_i) begin
    rsp_item_t want;
    if (rst_ni === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (awaited_rsps.size() == 0) begin
        report_mismatch($sformatf("unexpected result, status %0d", rsp_if.status));
      end else begin
        want = awaited_rsps.pop_front();
        check_field("status", 8'(rsp_if.status), 8'(want.status));
        check_field("page_number", rsp_if.page_number, want.page);
        check_field("page_offset", 8'(rsp_if.page_offset), 8'(want.offset));
        check_field("write_byte", rsp_if.write_byte, want.data);
        check_field("chunk_last", 8'(rsp_if.chunk_last), 8'(want.clast));
        check_field("task_finished", 8'(rsp_if.task_finished), 8'(want.fin));
        status_seen[want.status]++;
      end
      results_seen++;
    end
  end

  // ---------------------------------------------------------------------------------------
  // receiver: stall pattern of its own, with a long hold-off on request
  // ---------------------------------------------------------------------------------------
  bit          hold_request = 1'b0;
  int unsigned hold_left    = 0;
  int unsigned stall_mode   = 0;
  int unsigned mode_left    = 0;
  int unsigned rx_cycle     = 0;

  always @(posedge clk_i) begin
    rx_cycle++;
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(50, 300);
    end else begin
      mode_left--;
    end
    if (hold_left != 0) begin
      hold_left--;
      rsp_if.ready <= 1'b0;
    end else begin
      case (stall_mode)
        0:       rsp_if.ready <= 1'b1;                       // no stalls
        1:       rsp_if.ready <= 1'($urandom_range(0, 1));
        2:       rsp_if.ready <= (rx_cycle % 4 == 0);        // sparse periodic ready
        default: rsp_if.ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------------------
  // watchdog: only counts while something is offered or owed
  // ---------------------------------------------------------------------------------------
  int unsigned stuck_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && (req_if.valid === 1'b1 || awaited_rsps.size() != 0) &&
        !(req_if.valid === 1'b1 && req_if.ready === 1'b1) &&
        !(rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
      stuck_cycles++;
    end else begin
      stuck_cycles = 0;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results owed", stuck_cycles,
               awaited_rsps.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // sender: bursts of random length; while sender_gaps is set they are separated by random gaps
  // ---------------------------------------------------------------------------------------
  bit          sender_gaps = 1'b1;
  int unsigned burst_left  = 0;

  task automatic send_item(input logic op, input logic [7:0] data, input logic last,
                           input logic [7:0] page, input logic [2:0] off);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = sender_gaps ? $urandom_range(0, 5) : 0;
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    req_if.valid        <= 1'b1;
    req_if.operation    <= op;
    req_if.data_byte    <= data;
    req_if.last_byte    <= last;
    req_if.start_page   <= page;
    req_if.start_offset <= off;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    // transfer taken at this edge
    step_task_queue(op, data, last, page, off);
    items_sent++;
  endtask

  task automatic send_service();
    send_item(OP_SERVICE, 8'($urandom), 1'($urandom), 8'($urandom), 3'($urandom));
  endtask

  // one task of len bytes with random content; page and offset only count on the first byte
  task automatic send_task_bytes(input int unsigned len, input logic [7:0] page,
                                 input logic [2:0] off);
    for (int unsigned i = 0; i < len; i++) begin
      send_item(OP_ENQUEUE, 8'($urandom), (i + 1 == len),
                (i == 0) ? page : 8'($urandom), (i == 0) ? off : 3'($urandom));
    end
  endtask

  task automatic drain_services();
    while (count_q != 0) send_service();
  endtask

  // sender pauses until every owed result has come back
  task automatic settle_queue();
    req_if.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (awaited_rsps.size() != 0);
  endtask

  // ---------------------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------------------

  // field extremes, empty queue with and without a task in fill, page wrap after 255
  task automatic test_directed();
    send_service();
    send_item(OP_ENQUEUE, 8'h00, 1'b0, 8'hFF, 3'd6);
    send_service();                                    // still empty while filling
    send_item(OP_ENQUEUE, 8'hFF, 1'b0, 8'h00, 3'd0);
    send_item(OP_ENQUEUE, 8'hA5, 1'b1, 8'h00, 3'd0);
    send_service();                                    // two bytes up to the page end
    send_service();                                    // last byte on page 0
    send_service();
    // full page from offset 0, later bytes carry all-ones page and offset
    send_item(OP_ENQUEUE, 8'h5A, 1'b0, 8'h00, 3'd0);
    for (int unsigned i = 1; i < PAGE; i++) begin
      send_item(OP_ENQUEUE, 8'(i * 37), (i == PAGE - 1), 8'hFF, 3'd7);
    end
    send_service();
    // single-byte task at the last offset
    send_item(OP_ENQUEUE, 8'hC3, 1'b1, 8'h80, 3'd7);
    send_service();
  endtask

  // fill all slots, reject with and without a trailing drop, service during a drop
  task automatic test_queue_full();
    // head task is a single byte so one service retires it
    for (int unsigned i = 0; i < QDEPTH; i++) begin
      send_task_bytes((i == 0) ? 1 : $urandom_range(1, 3), 8'($urandom), 3'($urandom));
    end
    send_task_bytes(1, 8'($urandom), 3'($urandom));    // rejected, nothing to drop
    send_item(OP_ENQUEUE, 8'($urandom), 1'b0, 8'($urandom), 3'($urandom));
    send_service();                                    // frees a slot mid-drop
    send_item(OP_ENQUEUE, 8'($urandom), 1'b0, 8'($urandom), 3'($urandom));
    send_item(OP_ENQUEUE, 8'($urandom), 1'b1, 8'($urandom), 3'($urandom));
    send_task_bytes(2, 8'($urandom), 3'($urandom));    // now accepted
    drain_services();
    send_service();
  endtask

  // longest task that fits, then over-long tasks ending on and after the rejected byte
  task automatic test_too_long();
    send_task_bytes(MAXB, 8'hFE, 3'($urandom_range(1, 7)));
    drain_services();
    send_task_bytes(MAXB + 1, 8'($urandom), 3'($urandom));
    send_task_bytes(MAXB + 2, 8'($urandom), 3'($urandom));
    send_task_bytes(1, 8'($urandom), 3'($urandom));
    drain_services();
  endtask

  // receiver holds off while the sender keeps offering, so the block backs up
  task automatic test_backpressure();
    sender_gaps  = 1'b0;
    hold_request = 1'b1;
    for (int unsigned i = 0; i < 3; i++) send_task_bytes(PAGE, 8'($urandom), 3'd0);
    for (int unsigned i = 0; i < 4; i++) send_service();
    send_task_bytes(5, 8'($urandom), 3'($urandom));
    drain_services();
    sender_gaps = 1'b1;
  endtask

  // mostly well-formed tasks with random content, services, split tasks and noise
  task automatic test_random();
    int unsigned stop_at, pick, len, cut;
    stop_at = items_sent + 45;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 9);
      if (pick <= 3) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        send_task_bytes(len, 8'($urandom), 3'($urandom));
      end else if (pick == 4) begin
        // a service lands while a task is partly filled
        len = $urandom_range(2, 10);
        cut = $urandom_range(1, len - 1);
        send_task_bytes(cut, 8'($urandom), 3'($urandom));
        send_service();
        for (int unsigned i = cut; i < len; i++) begin
          send_item(OP_ENQUEUE, 8'($urandom), (i + 1 == len), 8'($urandom), 3'($urandom));
        end
      end else if (pick <= 8) begin
        send_service();
      end else begin
        send_item(1'($urandom), 8'($urandom), 1'($urandom), 8'($urandom), 3'($urandom));
      end
    end
    // close any task left open by noise, then empty the queue
    if (fill_q != 0 || drop_q) send_item(OP_ENQUEUE, 8'($urandom), 1'b1, 8'h00, 3'd0);
    drain_services();
  endtask

  initial begin
    rst_ni              = 1'b0;
    req_if.valid        = 1'b0;
    req_if.operation    = OP_ENQUEUE;
    req_if.data_byte    = '0;
    req_if.last_byte    = 1'b0;
    req_if.start_page   = '0;
    req_if.start_offset = '0;
    rsp_if.ready        = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    settle_queue();
    test_queue_full();
    settle_queue();
    test_too_long();
    settle_queue();
    test_backpressure();
    settle_queue();
    test_random();
    settle_queue();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (awaited_rsps.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", awaited_rsps.size()));
    end

    $display("covered %0d request transfers and %0d result transfers", items_sent,
             results_seen);
    $display("writes %0d, queued %0d, full %0d, empty %0d, too long %0d",
             status_seen[ST_WRITE], status_seen[ST_QUEUED], status_seen[ST_FULL],
             status_seen[ST_EMPTY], status_seen[ST_TOO_LONG]);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
